/* hw/rtl/mbrp_pkg.sv */
// Shared types, codes and constants for the Modbus register request parser.
package mbrp_pkg;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_FC  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_FC = 1'b1;
    localparam logic [7:0] READ_FC_RESET  = 8'd3;
    localparam logic [7:0] WRITE_FC_RESET = 8'd16;

    // PDU byte positions and lengths.
    localparam int POS_FUNC        = 0;
    localparam int POS_ADDR_HI     = 1;
    localparam int POS_ADDR_LO     = 2;
    localparam int POS_COUNT_HI    = 3;
    localparam int POS_COUNT_LO    = 4;
    localparam int POS_BYTE_COUNT  = 5;
    localparam int POS_FIRST_WORD  = 7;
    localparam int READ_PDU_LEN    = 5;
    localparam int WRITE_MIN_LEN   = 6;

    // Result kinds.
    localparam logic KIND_WORD    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Request classes.
    localparam logic [1:0] CLASS_READ  = 2'd0;
    localparam logic [1:0] CLASS_WRITE = 2'd1;
    localparam logic [1:0] CLASS_OTHER = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_LENGTH  = 3'd1;
    localparam logic [2:0] ST_COUNT_MISM  = 3'd2;
    localparam logic [2:0] ST_LENGTH_MISM = 3'd3;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

    // Depth of the queue between the parser and the result stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [7:0] pdu_byte;
        logic       last_byte;
    } t_pdu_in;

    typedef struct packed {
        logic        result_kind;
        logic [1:0]  request_class;
        logic [2:0]  status;
        logic [15:0] reg_address;
        logic [15:0] reg_count;
        logic [6:0]  word_index;
        logic [15:0] word_value;
        logic        last;
    } t_result;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [7:0]           data;
    } t_cfg_wr;

    // One parsed event: a data word, a summary, or both.
    typedef struct packed {
        logic        word_v;
        logic        sum_v;
        logic [1:0]  rclass;
        logic [2:0]  status;
        logic [15:0] addr;
        logic [15:0] count;
        logic [6:0]  word_index;
        logic [15:0] word_value;
    } t_rec;

    function automatic logic [1:0] class_of(input logic [7:0] fn,
                                            input logic [7:0] rd_fc,
                                            input logic [7:0] wr_fc);
        logic [1:0] c;
        if (fn == rd_fc) c = CLASS_READ;
        else if (fn == wr_fc) c = CLASS_WRITE;
        else c = CLASS_OTHER;
        return c;
    endfunction

endpackage

/* hw/rtl/mbrp_front.sv */
// Byte parser: captures header fields, pairs data bytes and builds events.
module mbrp_front
    import mbrp_pkg::*;
#(
    parameter int MAX_PDU_BYTES = 256
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    input  logic    i_accept,
    input  t_pdu_in i_item,
    output logic    o_rec_push,
    output t_rec    o_rec
);

    localparam int PW = $clog2(MAX_PDU_BYTES + 1);

    logic [7:0]    r_rd_fc, r_wr_fc;
    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_func, n_func;
    logic [15:0]   r_addr, n_addr;
    logic [15:0]   r_count, n_count;
    logic [7:0]    r_decl, n_decl;
    logic [7:0]    r_hold, n_hold;
    logic          r_cok, n_cok;

    logic          overlong;
    logic          word_v;
    logic [1:0]    cls_cur, cls_new;
    logic [2:0]    status;
    logic [15:0]   pos16, idx16, data_len;

    always_comb begin
        overlong = (r_pos >= PW'(MAX_PDU_BYTES));
        pos16    = 16'(r_pos);
        idx16    = (pos16 - 16'(POS_FIRST_WORD)) >> 1;
        data_len = pos16 - 16'(WRITE_MIN_LEN - 1);
        cls_cur  = class_of(r_func, r_rd_fc, r_wr_fc);
        n_pos    = r_pos;
        n_func   = r_func;
        n_addr   = r_addr;
        n_count  = r_count;
        n_decl   = r_decl;
        n_hold   = r_hold;
        n_cok    = r_cok;
        word_v   = 1'b0;
        if (!overlong) begin
            priority if (r_pos == PW'(POS_FUNC)) begin
                n_func  = i_item.pdu_byte;
                n_addr  = '0;
                n_count = '0;
                n_decl  = '0;
                n_hold  = '0;
                n_cok   = 1'b0;
            end else if (r_pos == PW'(POS_ADDR_HI)) begin
                n_addr[15:8] = i_item.pdu_byte;
            end else if (r_pos == PW'(POS_ADDR_LO)) begin
                n_addr[7:0] = i_item.pdu_byte;
            end else if (r_pos == PW'(POS_COUNT_HI)) begin
                n_count[15:8] = i_item.pdu_byte;
            end else if (r_pos == PW'(POS_COUNT_LO)) begin
                n_count[7:0] = i_item.pdu_byte;
            end else if (r_pos == PW'(POS_BYTE_COUNT)) begin
                n_decl = i_item.pdu_byte;
                n_cok  = ({r_count, 1'b0} == {9'd0, i_item.pdu_byte});
            end else if (!r_pos[0]) begin
                n_hold = i_item.pdu_byte;
            end else begin
                word_v = (cls_cur == CLASS_WRITE) && r_cok && (idx16 < r_count);
            end
            n_pos = r_pos + PW'(1);
        end

        // The summary sees the state as updated by this byte.
        cls_new = class_of(n_func, r_rd_fc, r_wr_fc);
        unique case (cls_new)
            CLASS_READ: begin
                status = (!overlong && r_pos == PW'(READ_PDU_LEN - 1)) ? ST_OK
                                                                     : ST_BAD_LENGTH;
            end
            CLASS_WRITE: begin
                priority if (!overlong && r_pos < PW'(WRITE_MIN_LEN - 1)) begin
                    status = ST_BAD_LENGTH;
                end else if (!n_cok) begin
                    status = ST_COUNT_MISM;
                end else if (overlong || {8'd0, n_decl} != data_len) begin
                    status = ST_LENGTH_MISM;
                end else begin
                    status = ST_OK;
                end
            end
            default: status = ST_UNSUPPORTED;
        endcase
    end

    assign o_rec_push       = i_accept && (word_v || i_item.last_byte);
    assign o_rec.word_v     = word_v;
    assign o_rec.sum_v      = i_item.last_byte;
    assign o_rec.rclass     = cls_new;
    assign o_rec.status     = status;
    assign o_rec.addr       = n_addr;
    assign o_rec.count      = n_count;
    assign o_rec.word_index = idx16[6:0];
    assign o_rec.word_value = {r_hold, i_item.pdu_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_fc <= READ_FC_RESET;
            r_wr_fc <= WRITE_FC_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_READ_FC) r_rd_fc <= i_cfg.data;
            if (i_cfg.index == CFG_WRITE_FC) r_wr_fc <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_item.last_byte)) begin
            r_pos   <= '0;
            r_func  <= '0;
            r_addr  <= '0;
            r_count <= '0;
            r_decl  <= '0;
            r_hold  <= '0;
            r_cok   <= 1'b0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_func  <= n_func;
            r_addr  <= n_addr;
            r_count <= n_count;
            r_decl  <= n_decl;
            r_hold  <= n_hold;
            r_cok   <= n_cok;
        end
    end

    // A final byte always leaves the parser ready for a new PDU.
    a_pos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_item.last_byte |=> r_pos == '0 && !r_cok)
        else $error("byte position not cleared after final byte");

endmodule

/* hw/rtl/mbrp_queue.sv */
// Small event queue between the parser and the result stage.
module mbrp_queue
    import mbrp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    output logic o_full,
    input  logic i_pop,
    output t_rec o_rec,
    output logic o_empty
);

    t_rec              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]   r_fill;

    assign o_full  = (r_fill == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            if (i_pop) r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            unique case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + (QUEUE_AW + 1)'(1);
                2'b01:   r_fill <= r_fill - (QUEUE_AW + 1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (QUEUE_AW + 1)'(QUEUE_DEPTH) && !(i_push && o_full && !i_pop))
        else $error("event queue overflow");

endmodule

/* hw/rtl/mbrp_back.sv */
// Result stage: expands queued events into word and summary results.
module mbrp_back
    import mbrp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_rec    i_rec,
    input  logic    i_rec_empty,
    output logic    o_rec_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    t_rec    r_cur, n_cur;
    logic    r_cur_valid, n_cur_valid;
    t_result r_out, n_out;
    logic    r_out_valid, n_out_valid;
    logic    out_free, cur_done;

    always_comb begin
        out_free    = !r_out_valid || i_pop;
        cur_done    = 1'b0;
        n_cur       = r_cur;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        if (r_cur_valid && out_free) begin
            n_out_valid = 1'b1;
            if (r_cur.word_v) begin
                n_out.result_kind   = KIND_WORD;
                n_out.request_class = CLASS_WRITE;
                n_out.status        = ST_OK;
                n_out.reg_address   = r_cur.addr;
                n_out.reg_count     = r_cur.count;
                n_out.word_index    = r_cur.word_index;
                n_out.word_value    = r_cur.word_value;
                n_out.last          = 1'b0;
                n_cur.word_v        = 1'b0;
                cur_done            = !r_cur.sum_v;
            end else begin
                n_out.result_kind   = KIND_SUMMARY;
                n_out.request_class = r_cur.rclass;
                n_out.status        = r_cur.status;
                n_out.reg_address   = (r_cur.status == ST_OK) ? r_cur.addr : 16'd0;
                n_out.reg_count     = (r_cur.status == ST_OK) ? r_cur.count : 16'd0;
                n_out.word_index    = '0;
                n_out.word_value    = '0;
                n_out.last          = 1'b1;
                cur_done            = 1'b1;
            end
        end
        o_rec_pop = !i_rec_empty && (!r_cur_valid || cur_done);
        if (o_rec_pop) begin
            n_cur       = i_rec;
            n_cur_valid = 1'b1;
        end else begin
            n_cur_valid = r_cur_valid && !cur_done;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur_valid <= n_cur_valid;
            r_out_valid <= n_out_valid;
        end
    end

    a_word_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.result_kind == KIND_WORD |->
            r_out.request_class == CLASS_WRITE && r_out.status == ST_OK && !r_out.last)
        else $error("malformed data word result");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.result_kind == KIND_SUMMARY && r_out.status != ST_OK |->
            r_out.reg_address == '0 && r_out.reg_count == '0 && r_out.last)
        else $error("failed summary carries address or count");

endmodule

/* hw/rtl/modbus_register_request_parser_unit.sv */
// Top level of the Modbus register request parser.
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   -----------------------------------------
//  input     push / full               i_item   (pdu_byte, last_byte)
//  result    empty / pop               o_result (kind, class, status, address,
//                                      count, word index, word value, last)
//  config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// The parser takes one PDU byte in every cycle; its header fields and the held
// high data byte are updated as each byte is taken, so the byte rate is one per
// clock while full is low. Events pass through the event queue, the current-event
// register and the output register to the result ports. Results leave at one per
// clock while pop keeps up; a final byte completing a data word makes two results.
// Reset is synchronous and active low: it clears the parser state and the queues
// and sets the function codes to 3 (read) and 16 (write multiple).
// full rises only when the four-entry event queue is full, which happens only
// when the consumer stalls pop; while it is high every byte waits, including
// bytes that make no result.
module modbus_register_request_parser_unit
    import mbrp_pkg::*;
#(
    parameter int MAX_PDU_BYTES = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  t_pdu_in              i_item,
    output logic                 empty,
    input  logic                 pop,
    output t_result              o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    t_cfg_wr cfg;
    t_rec    push_rec, head_rec;
    logic    accept, rec_push, rec_pop, q_empty;

    // Configuration writes are taken at once; the function codes are plain registers.
    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    // A request byte is taken whenever the event queue has room.
    assign accept = push && !full;

    mbrp_front #(
        .MAX_PDU_BYTES(MAX_PDU_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_accept  (accept),
        .i_item    (i_item),
        .o_rec_push(rec_push),
        .o_rec     (push_rec)
    );

    // The queue lets the parser keep taking bytes while the result side stalls.
    mbrp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (rec_push),
        .i_rec  (push_rec),
        .o_full (full),
        .i_pop  (rec_pop),
        .o_rec  (head_rec),
        .o_empty(q_empty)
    );

    // The result stage emits a data word before the summary of the same byte.
    mbrp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rec      (head_rec),
        .i_rec_empty(q_empty),
        .o_rec_pop  (rec_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (o_result)
    );

endmodule
